>>> rtl/pqfg_pkg.sv
`timescale 1ns / 1ps
// Package for the piecewise quadratic function generator.
// Holds the table geometry, the segment entry layout, codes and the saturation helper.
// No dependencies.

package pqfg_pkg;

    // Table geometry.
    parameter int MAX_SEGMENTS = 32;
    parameter int PTR_W        = $clog2(MAX_SEGMENTS);

    // Field widths fixed by the interface.
    parameter int DATA_W    = 32;
    parameter int COUNT_W   = 6;
    parameter int SEGNUM_W  = 5;
    parameter int PHASE_W   = 2;
    parameter int CFG_IDX_W = 2;

    // Fixed point: time is Q12.20, so products are scaled back by 20 bits.
    parameter int FRAC_SHIFT = 20;
    parameter int DT_W       = DATA_W + 1;
    parameter int PROD_W     = DATA_W + DT_W;
    parameter int SUM_W      = PROD_W - FRAC_SHIFT + 1;

    // Command codes.
    parameter logic CMD_LOAD = 1'b0;
    parameter logic CMD_EVAL = 1'b1;

    // Phase codes of a result.
    parameter logic [PHASE_W-1:0] PHASE_PRE    = 2'd0;
    parameter logic [PHASE_W-1:0] PHASE_DURING = 2'd1;
    parameter logic [PHASE_W-1:0] PHASE_POST   = 2'd2;

    // Configuration register indexes.
    parameter logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 2'd0;
    parameter logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 2'd1;

    // One table entry: end time and the three coefficients.
    typedef struct packed {
        logic [DATA_W-1:0] end_time;
        logic [DATA_W-1:0] level;
        logic [DATA_W-1:0] rate;
        logic [DATA_W-1:0] curve;
    } seg_entry_t;

    parameter int ENTRY_W = $bits(seg_entry_t);

    // Strobes from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic load_seg;
        logic calc_dt;
        logic mul_first;
        logic add_rate;
        logic mul_second;
    } arith_ctrl_t;

    // Clamp a wide two's complement sum to signed 32 bit.
    function automatic logic [DATA_W-1:0] sat_data(input logic [SUM_W-1:0] v);
        logic [SUM_W-DATA_W:0] upper;
        logic [DATA_W-1:0]     res;
        upper = v[SUM_W-1:DATA_W-1];
        if ((&upper) || !(|upper)) begin
            res = v[DATA_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

>>> rtl/pqfg_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module pqfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/pqfg_arith.sv
`timescale 1ns / 1ps
// Arithmetic unit: dt, a shared 32x33 multiplier and two saturating adds.
// Depends on pqfg_pkg.

module pqfg_arith (
    input  logic                         aclk,
    input  pqfg_pkg::arith_ctrl_t        ctl,
    input  pqfg_pkg::seg_entry_t         rd_entry,
    input  logic signed [pqfg_pkg::DATA_W-1:0] time_value,
    output logic [pqfg_pkg::DATA_W-1:0]  eval_level
);

    pqfg_pkg::seg_entry_t                     seg_reg;
    logic signed [pqfg_pkg::DT_W-1:0]         dt_reg;
    logic signed [pqfg_pkg::DT_W-1:0]         dt_next;
    logic signed [pqfg_pkg::PROD_W-1:0]       prod_reg;
    logic signed [pqfg_pkg::PROD_W-1:0]       prod_next;
    logic signed [pqfg_pkg::DATA_W-1:0]       inner_reg;
    logic [pqfg_pkg::DATA_W-1:0]              inner_next;
    logic signed [pqfg_pkg::DATA_W-1:0]       mul_a;
    logic [pqfg_pkg::SUM_W-1:0]               scaled_prod;
    logic [pqfg_pkg::SUM_W-1:0]               rate_sum;
    logic [pqfg_pkg::SUM_W-1:0]               level_sum;

    // The product is scaled back with a floor shift, kept one bit wider for the add.
    assign scaled_prod = {prod_reg[pqfg_pkg::PROD_W-1],
                          prod_reg[pqfg_pkg::PROD_W-1:pqfg_pkg::FRAC_SHIFT]};

    assign dt_next = {time_value[pqfg_pkg::DATA_W-1], time_value}
                   - {seg_reg.end_time[pqfg_pkg::DATA_W-1], seg_reg.end_time};

    assign mul_a     = ctl.mul_second ? inner_reg : $signed(seg_reg.curve);
    assign prod_next = mul_a * dt_reg;

    assign rate_sum = {{(pqfg_pkg::SUM_W-pqfg_pkg::DATA_W){seg_reg.rate[pqfg_pkg::DATA_W-1]}},
                       seg_reg.rate} + scaled_prod;
    assign level_sum = {{(pqfg_pkg::SUM_W-pqfg_pkg::DATA_W){seg_reg.level[pqfg_pkg::DATA_W-1]}},
                        seg_reg.level} + scaled_prod;

    assign inner_next = pqfg_pkg::sat_data(rate_sum);
    assign eval_level = pqfg_pkg::sat_data(level_sum);

    always_ff @(posedge aclk) begin
        if (ctl.load_seg) begin
            seg_reg <= rd_entry;
        end
        if (ctl.calc_dt) begin
            dt_reg <= dt_next;
        end
        if (ctl.mul_first || ctl.mul_second) begin
            prod_reg <= prod_next;
        end
        if (ctl.add_rate) begin
            inner_reg <= $signed(inner_next);
        end
    end

endmodule

>>> rtl/pqfg_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: configuration registers, segment pointer walk over the table RAM,
// arithmetic strobes and the result register. Depends on pqfg_pkg.

module pqfg_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic [pqfg_pkg::SEGNUM_W-1:0]      s_segment_number,
    input  logic signed [pqfg_pkg::DATA_W-1:0] s_time_point,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pqfg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pqfg_pkg::DATA_W-1:0]        cfg_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pqfg_pkg::DATA_W-1:0] m_level,
    output logic [pqfg_pkg::PHASE_W-1:0]       m_phase,
    output logic                               ram_we,
    output logic [pqfg_pkg::PTR_W-1:0]         ram_waddr,
    output logic                               ram_re,
    output logic [pqfg_pkg::PTR_W-1:0]         ram_raddr,
    input  pqfg_pkg::seg_entry_t               ram_rdata,
    output pqfg_pkg::arith_ctrl_t              arith_ctl,
    output logic signed [pqfg_pkg::DATA_W-1:0] time_value,
    input  logic [pqfg_pkg::DATA_W-1:0]        eval_level
);

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_FWD_RD  = 11'b000_0000_0010,
        ST_FWD_CHK = 11'b000_0000_0100,
        ST_BK_RD   = 11'b000_0000_1000,
        ST_BK_CHK  = 11'b000_0001_0000,
        ST_DT      = 11'b000_0010_0000,
        ST_MUL1    = 11'b000_0100_0000,
        ST_ADD1    = 11'b000_1000_0000,
        ST_MUL2    = 11'b001_0000_0000,
        ST_ADD2    = 11'b010_0000_0000,
        ST_OUT     = 11'b100_0000_0000
    } ctrl_state_t;

    ctrl_state_t                         state_reg, state_next;
    logic [pqfg_pkg::PTR_W-1:0]          ptr_reg, ptr_next;
    logic [pqfg_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [pqfg_pkg::DATA_W-1:0]         init_reg, init_next;
    logic signed [pqfg_pkg::DATA_W-1:0]  time_reg, time_next;
    logic [pqfg_pkg::DATA_W-1:0]         res_level_reg, res_level_next;
    logic [pqfg_pkg::PHASE_W-1:0]        res_phase_reg, res_phase_next;
    logic                                m_valid_reg, m_valid_next;
    logic [pqfg_pkg::DATA_W-1:0]         m_level_reg, m_level_next;
    logic [pqfg_pkg::PHASE_W-1:0]        m_phase_reg, m_phase_next;

    logic [pqfg_pkg::PTR_W-1:0]          last_idx;
    logic [pqfg_pkg::PTR_W-1:0]          ptr_clamped;
    logic [pqfg_pkg::PTR_W-1:0]          ptr_dec;
    logic                                s_fire;
    logic                                load_ok;
    logic                                out_free;
    logic                                time_after;
    logic                                time_before;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign ptr_dec   = ptr_reg - pqfg_pkg::PTR_W'(1);

    assign m_valid    = m_valid_reg;
    assign m_level    = $signed(m_level_reg);
    assign m_phase    = m_phase_reg;
    assign time_value = time_reg;

    // Loads to entries past the table are dropped.
    assign load_ok   = (32'(s_segment_number) < pqfg_pkg::MAX_SEGMENTS);
    assign ram_we    = s_fire && (s_command == pqfg_pkg::CMD_LOAD) && load_ok;
    assign ram_waddr = pqfg_pkg::PTR_W'(s_segment_number);

    assign ram_re    = (state_reg == ST_FWD_RD) || (state_reg == ST_BK_RD);
    assign ram_raddr = (state_reg == ST_BK_RD) ? ptr_dec : ptr_reg;

    assign time_after  = time_reg > $signed(ram_rdata.end_time);
    assign time_before = time_reg < $signed(ram_rdata.end_time);

    // Index of the last active segment; a zero count acts as one.
    always_comb begin
        if (count_reg == '0) begin
            last_idx = '0;
        end else if (32'(count_reg) > pqfg_pkg::MAX_SEGMENTS) begin
            last_idx = pqfg_pkg::PTR_W'(pqfg_pkg::MAX_SEGMENTS - 1);
        end else begin
            last_idx = pqfg_pkg::PTR_W'(count_reg - 6'd1);
        end
    end

    assign ptr_clamped = (ptr_reg > last_idx) ? last_idx : ptr_reg;

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        init_next      = init_reg;
        time_next      = time_reg;
        res_level_next = res_level_reg;
        res_phase_next = res_phase_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_level_next   = m_level_reg;
        m_phase_next   = m_phase_reg;
        arith_ctl      = '0;

        if (cfg_valid) begin
            if (cfg_index == pqfg_pkg::REG_SEGMENT_COUNT) begin
                count_next = cfg_data[pqfg_pkg::COUNT_W-1:0];
            end else if (cfg_index == pqfg_pkg::REG_INITIAL_LEVEL) begin
                init_next = cfg_data;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_command == pqfg_pkg::CMD_EVAL)) begin
                    time_next = s_time_point;
                    if (s_time_point[pqfg_pkg::DATA_W-1]) begin
                        ptr_next       = '0;
                        res_level_next = init_reg;
                        res_phase_next = pqfg_pkg::PHASE_PRE;
                        state_next     = ST_OUT;
                    end else begin
                        ptr_next   = ptr_clamped;
                        state_next = ST_FWD_RD;
                    end
                end
            end
            ST_FWD_RD: begin
                state_next = ST_FWD_CHK;
            end
            ST_FWD_CHK: begin
                if (time_after) begin
                    if (ptr_reg == last_idx) begin
                        res_level_next = ram_rdata.level;
                        res_phase_next = pqfg_pkg::PHASE_POST;
                        state_next     = ST_OUT;
                    end else begin
                        ptr_next   = ptr_reg + pqfg_pkg::PTR_W'(1);
                        state_next = ST_FWD_RD;
                    end
                end else begin
                    arith_ctl.load_seg = 1'b1;
                    state_next = (ptr_reg != '0) ? ST_BK_RD : ST_DT;
                end
            end
            ST_BK_RD: begin
                state_next = ST_BK_CHK;
            end
            ST_BK_CHK: begin
                if (time_before) begin
                    arith_ctl.load_seg = 1'b1;
                    ptr_next   = ptr_dec;
                    state_next = (ptr_dec != '0) ? ST_BK_RD : ST_DT;
                end else begin
                    state_next = ST_DT;
                end
            end
            ST_DT: begin
                arith_ctl.calc_dt = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                arith_ctl.mul_first = 1'b1;
                state_next = ST_ADD1;
            end
            ST_ADD1: begin
                arith_ctl.add_rate = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                arith_ctl.mul_second = 1'b1;
                state_next = ST_ADD2;
            end
            ST_ADD2: begin
                res_level_next = eval_level;
                res_phase_next = pqfg_pkg::PHASE_DURING;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_level_next = res_level_reg;
                    m_phase_next = res_phase_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            count_reg   <= pqfg_pkg::COUNT_W'(1);
            init_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        time_reg      <= time_next;
        res_level_reg <= res_level_next;
        res_phase_reg <= res_phase_next;
        m_level_reg   <= m_level_next;
        m_phase_reg   <= m_phase_next;
    end

endmodule

>>> rtl/piecewise_quadratic_function_generator.sv
`timescale 1ns / 1ps
// Top level of the piecewise quadratic function generator.
// Depends on pqfg_pkg, pqfg_ram, pqfg_arith and pqfg_ctrl.

// The block holds a table of up to 32 segments in one RAM, each entry an end
// time (Q12.20 seconds) and coefficients a0, a1, a2 (Q16.16) referenced to that
// end time. A load item writes one entry and produces no result; ready stays
// high, so loads can stream back to back. An evaluate item gives a time and
// produces exactly one result. A negative time resets the segment pointer and
// returns the initial level with phase pre without reading the table. Otherwise
// the pointer walks forward, then back, one table read per step, to the segment
// that holds the time, and the level a0 + (a1 + a2*dt)*dt is formed with two
// passes through one shared 32x33 multiplier, products floored and both sums
// saturated. Each step of the walk is one registered read of the table RAM
// followed by a compare, and the block takes no new item until the evaluate
// item is done. Past the last end time the last a0 is returned with phase post.
// A finished result sits in an output register, so the next item is accepted
// while the result waits for m_ready; only an evaluate item that finishes while
// that register is still full waits for it. Table entries must be loaded before
// they are reached by an evaluation; the RAM has no reset. Configuration writes
// (segment count, initial level) are taken in any cycle and must only be issued
// while the block is idle.

module piecewise_quadratic_function_generator (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Item input channel.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic [pqfg_pkg::SEGNUM_W-1:0]      s_segment_number,
    input  logic signed [pqfg_pkg::DATA_W-1:0] s_end_time,
    input  logic signed [pqfg_pkg::DATA_W-1:0] s_coef_level,
    input  logic signed [pqfg_pkg::DATA_W-1:0] s_coef_rate,
    input  logic signed [pqfg_pkg::DATA_W-1:0] s_coef_curve,
    input  logic signed [pqfg_pkg::DATA_W-1:0] s_time_point,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pqfg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pqfg_pkg::DATA_W-1:0]        cfg_data,
    // Result channel.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pqfg_pkg::DATA_W-1:0] m_level,
    output logic [pqfg_pkg::PHASE_W-1:0]       m_phase
);

    logic                               ram_we;
    logic [pqfg_pkg::PTR_W-1:0]         ram_waddr;
    logic                               ram_re;
    logic [pqfg_pkg::PTR_W-1:0]         ram_raddr;
    pqfg_pkg::seg_entry_t               ram_wentry;
    logic [pqfg_pkg::ENTRY_W-1:0]       ram_rdata;
    pqfg_pkg::seg_entry_t               ram_rentry;
    pqfg_pkg::arith_ctrl_t              arith_ctl;
    logic signed [pqfg_pkg::DATA_W-1:0] time_value;
    logic [pqfg_pkg::DATA_W-1:0]        eval_level;

    // A load item is written straight from the input ports.
    assign ram_wentry.end_time = s_end_time;
    assign ram_wentry.level    = s_coef_level;
    assign ram_wentry.rate     = s_coef_rate;
    assign ram_wentry.curve    = s_coef_curve;
    assign ram_rentry          = ram_rdata;

    pqfg_ram #(
        .WIDTH (pqfg_pkg::ENTRY_W),
        .DEPTH (pqfg_pkg::MAX_SEGMENTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pqfg_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_segment_number (s_segment_number),
        .s_time_point     (s_time_point),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_level          (m_level),
        .m_phase          (m_phase),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rentry),
        .arith_ctl        (arith_ctl),
        .time_value       (time_value),
        .eval_level       (eval_level)
    );

    pqfg_arith u_arith (
        .aclk       (aclk),
        .ctl        (arith_ctl),
        .rd_entry   (ram_rentry),
        .time_value (time_value),
        .eval_level (eval_level)
    );

endmodule

>>> rtl/pqfg_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the piecewise quadratic function generator, with its bind.
// Depends on pqfg_pkg and the top level's ports.

module pqfg_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               s_command,
    input logic signed [pqfg_pkg::DATA_W-1:0] s_time_point,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [pqfg_pkg::DATA_W-1:0] m_level,
    input logic [pqfg_pkg::PHASE_W-1:0]       m_phase
);

    // A load item never produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == pqfg_pkg::CMD_LOAD) && !m_valid) |=> !m_valid)
        else $error("load item produced a result");

    // An evaluate item holds off the next item while it is worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == pqfg_pkg::CMD_EVAL)) |=> !s_ready)
        else $error("ready stayed high after an evaluate item");

    // A negative time is answered with phase pre.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == pqfg_pkg::CMD_EVAL)
         && s_time_point[pqfg_pkg::DATA_W-1] && !m_valid)
        |-> ##2 (m_valid && (m_phase == pqfg_pkg::PHASE_PRE)))
        else $error("negative time not answered with phase pre");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_level) && $stable(m_phase)))
        else $error("stalled result changed");

endmodule

bind piecewise_quadratic_function_generator pqfg_checker u_pqfg_checker (.*);
